// ===== rtl/sexpr_pkg.sv =====
// Shared types and constants of the s-expression lexer.
package sexpr_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxFrac = 18;

  typedef enum logic [3:0] {
    TOK_END    = 4'd0,
    TOK_INT    = 4'd1,
    TOK_REAL   = 4'd2,
    TOK_STRING = 4'd3,
    TOK_LPAREN = 4'd4,
    TOK_RPAREN = 4'd5,
    TOK_IDENT  = 4'd6,
    TOK_QUOTE  = 4'd7,
    TOK_DOT    = 4'd8,
    TOK_BAD    = 4'd9,
    TOK_UNTERM = 4'd10
  } tok_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       input_ended;
  } in_beat_t;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        text_byte;
    logic [3:0]        token_kind;
    logic signed [63:0] number_value;
    logic [4:0]        fraction_digits;
    logic              last_of_run;
  } out_beat_t;

  // One classified character with at most two results ready to emit.
  typedef struct packed {
    logic [1:0] count;
    out_beat_t  res0;
    out_beat_t  res1;
  } work_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h25 ||
           c == 8'h26 || c == 8'h3c || c == 8'h3e || c == 8'h3d || c == 8'h5f ||
           c == 8'h3f;
  endfunction

endpackage

// ===== rtl/sexpr_if.sv =====
// Valid/ready channel interface carrying one payload beat.
interface sexpr_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sexpr_front.sv =====
// Front end: lexer state machine that turns each character into up to two results.
module sexpr_front import sexpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     ready_o,
  output logic     push_o,
  output work_t    work_o,
  input  logic     full_i
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_MINUS, M_IDENT, M_INT, M_REAL, M_STR, M_ESC, M_OCT, M_HEX
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [63:0] acc_q, acc_d;
  logic [4:0]  frac_q, frac_d;
  logic        minus_q, minus_d;
  logic [7:0]  esc_q, esc_d;
  logic [1:0]  escn_q, escn_d;

  out_beat_t r [2];
  logic [1:0] n;
  logic [7:0] c;
  logic [63:0] acc10;
  logic [3:0] hv;
  logic       hok;

  assign ready_o = !full_i;
  assign push_o  = valid_i && ready_o;
  assign c       = beat_i.char_code;
  assign acc10   = (acc_q << 3) + (acc_q << 1) + {56'd0, c - 8'h30};

  always_comb begin
    hok = 1'b1;
    hv  = '0;
    if (is_digit(c)) begin
      hv = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hv = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hv = 4'(c - 8'h57);
    end else begin
      hok = 1'b0;
    end
  end

  always_comb begin
    logic [63:0] v;
    logic        restart;
    logic        strc;
    logic [7:0]  sc;
    mode_d  = mode_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    minus_d = minus_q;
    esc_d   = esc_q;
    escn_d  = escn_q;
    n       = '0;
    r[0]    = '0;
    r[1]    = '0;
    restart = 1'b0;
    strc    = 1'b0;
    sc      = c;
    v       = minus_q ? 64'd0 - acc_q : acc_q;
    if (beat_i.input_ended) begin
      case (mode_q)
        M_MINUS, M_IDENT: begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_IDENT; n = n + 2'd1;
        end
        M_INT: begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_INT;
          r[n[0]].number_value = v; n = n + 2'd1;
        end
        M_REAL: begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_REAL;
          r[n[0]].number_value = v; r[n[0]].fraction_digits = frac_q; n = n + 2'd1;
        end
        M_STR, M_ESC, M_OCT, M_HEX: begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_UNTERM; n = n + 2'd1;
        end
        default: ;
      endcase
      r[n[0]].result_kind = 1'b1;
      r[n[0]].token_kind  = TOK_END;
      n = n + 2'd1;
      mode_d = M_IDLE; acc_d = '0; frac_d = '0; minus_d = 1'b0; esc_d = '0; escn_d = '0;
    end else begin
      case (mode_q)
        M_COMMENT: if (c == 8'h0a) mode_d = M_IDLE;
        M_MINUS: begin
          if (is_digit(c)) begin
            acc_d = {56'd0, c - 8'h30}; frac_d = '0; minus_d = 1'b1; mode_d = M_INT;
          end else if (is_sym(c)) begin
            r[n[0]].text_byte = c; n = n + 2'd1; mode_d = M_IDENT;
          end else begin
            r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_IDENT; n = n + 2'd1;
            restart = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || is_sym(c)) begin
            r[n[0]].text_byte = c; n = n + 2'd1;
          end else begin
            r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_IDENT; n = n + 2'd1;
            restart = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            acc_d = acc10;
          end else if (c == 8'h2e) begin
            frac_d = '0; mode_d = M_REAL;
          end else begin
            r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_INT;
            r[n[0]].number_value = v; n = n + 2'd1;
            acc_d = '0; frac_d = '0; minus_d = 1'b0; restart = 1'b1;
          end
        end
        M_REAL: begin
          if (is_digit(c)) begin
            if (frac_q < 5'(MaxFrac)) begin
              acc_d = acc10; frac_d = frac_q + 5'd1;
            end
          end else begin
            r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_REAL;
            r[n[0]].number_value = v; r[n[0]].fraction_digits = frac_q; n = n + 2'd1;
            acc_d = '0; frac_d = '0; minus_d = 1'b0; restart = 1'b1;
          end
        end
        M_STR: strc = 1'b1;
        M_ESC: begin
          mode_d = M_STR;
          case (c)
            8'h6e: sc = 8'd10;
            8'h72: sc = 8'd13;
            8'h74: sc = 8'd9;
            8'h66: sc = 8'd12;
            8'h62: sc = 8'd8;
            8'h76: sc = 8'd11;
            8'h61: sc = 8'd7;
            default: sc = c;
          endcase
          if (c == 8'h78) begin
            esc_d = '0; escn_d = '0; mode_d = M_HEX;
          end else if (c >= 8'h30 && c <= 8'h37) begin
            esc_d = c - 8'h30; escn_d = 2'd1; mode_d = M_OCT;
          end else begin
            r[n[0]].text_byte = sc; n = n + 2'd1;
          end
        end
        M_OCT: begin
          if (c >= 8'h30 && c <= 8'h37) begin
            esc_d = {esc_q[4:0], 3'b000} + (c - 8'h30);
            escn_d = escn_q + 2'd1;
            if (escn_q == 2'd2) begin
              r[n[0]].text_byte = esc_d; n = n + 2'd1; mode_d = M_STR;
            end
          end else begin
            r[n[0]].text_byte = esc_q; n = n + 2'd1; strc = 1'b1;
          end
        end
        M_HEX: begin
          if (hok) begin
            esc_d = {esc_q[3:0], hv};
            escn_d = escn_q + 2'd1;
            if (escn_q == 2'd1) begin
              r[n[0]].text_byte = esc_d; n = n + 2'd1; mode_d = M_STR;
            end
          end else begin
            r[n[0]].text_byte = (escn_q == 2'd0) ? 8'h78 : esc_q; n = n + 2'd1;
            strc = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (strc) begin
        mode_d = M_STR;
        if (c == 8'h22) begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_STRING; n = n + 2'd1;
          mode_d = M_IDLE;
        end else if (c == 8'h5c) begin
          mode_d = M_ESC;
        end else begin
          r[n[0]].text_byte = c; n = n + 2'd1;
        end
      end
      if (restart) begin
        mode_d = M_IDLE;
        if (is_space(c)) begin
        end else if (c == 8'h3b) begin
          mode_d = M_COMMENT;
        end else if (c == 8'h28) begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_LPAREN; n = n + 2'd1;
        end else if (c == 8'h29) begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_RPAREN; n = n + 2'd1;
        end else if (c == 8'h27) begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_QUOTE; n = n + 2'd1;
        end else if (c == 8'h2e) begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_DOT; n = n + 2'd1;
        end else if (c == 8'h2d) begin
          r[n[0]].text_byte = c; n = n + 2'd1; mode_d = M_MINUS;
        end else if (is_digit(c)) begin
          acc_d = {56'd0, c - 8'h30}; frac_d = '0; minus_d = 1'b0; mode_d = M_INT;
        end else if (is_alpha(c) || is_sym(c)) begin
          r[n[0]].text_byte = c; n = n + 2'd1; mode_d = M_IDENT;
        end else if (c == 8'h22) begin
          mode_d = M_STR;
        end else begin
          r[n[0]].result_kind = 1'b1; r[n[0]].token_kind = TOK_BAD; n = n + 2'd1;
        end
      end
    end
    if (n == 2'd1) r[0].last_of_run = 1'b1;
    if (n == 2'd2) r[1].last_of_run = 1'b1;
  end

  assign work_o.count = n;
  assign work_o.res0  = r[0];
  assign work_o.res1  = r[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= '0;
      frac_q  <= '0;
      minus_q <= 1'b0;
      esc_q   <= '0;
      escn_q  <= '0;
    end else if (push_o) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      minus_q <= minus_d;
      esc_q   <= esc_d;
      escn_q  <= escn_d;
    end
  end

endmodule

// ===== rtl/sexpr_back.sv =====
// Back end: queue of classified work and the serializer that emits result beats.
module sexpr_back import sexpr_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  work_t     work_i,
  output logic      full_o,
  output logic      valid_o,
  output out_beat_t beat_o,
  input  logic      ready_i
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  work_t          mem_q [Depth];
  logic [Aw-1:0]  wr_q, rd_q;
  logic [Aw:0]    cnt_q;
  logic           sel_q;
  logic           pop, push, take, empty;
  work_t          head;

  assign empty   = cnt_q == '0;
  assign full_o  = cnt_q == (Aw+1)'(Depth);
  assign push    = push_i && work_i.count != 2'd0;
  assign head    = mem_q[rd_q];
  assign valid_o = !empty;
  assign beat_o  = sel_q ? head.res1 : head.res0;
  assign take    = valid_o && ready_i;
  assign pop     = take && (sel_q || head.count == 2'd1);

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= work_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sel_q <= 1'b0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
      if (pop) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
      if (pop) sel_q <= 1'b0;
      else if (take) sel_q <= 1'b1;
    end
  end

endmodule

// ===== rtl/sexpr_token_lexer.sv =====
// Top level of the s-expression token lexer.
// The in_ch channel carries one beat per character, or an end-of-input
// mark when input_ended is high. The out_ch channel carries result beats:
// text characters of identifiers and strings and completed tokens, with
// last_of_run set on the final beat caused by one input beat.
// The front end classifies one character per cycle, so input beats are
// taken back to back while the result queue has room. Each input beat
// gives zero, one or two result beats, which are registered in the queue
// and emitted behind any earlier entries. Output runs at one beat per
// cycle while the receiver is ready, so a character that yields two results sends res0 and then res1.
// Reset clears the lexer state to idle between tokens and empties the
// queue. When the receiver stalls, the queue of QueueDepth entries fills
// and then in_ch.ready drops until an entry drains.
module sexpr_token_lexer import sexpr_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  sexpr_if.sink   in_ch,
  sexpr_if.source out_ch
);

  logic  push, full;
  work_t work;

  sexpr_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_ch.valid), .beat_i(in_ch.data), .ready_o(in_ch.ready),
    .push_o(push), .work_o(work), .full_i(full)
  );

  sexpr_back #(.Depth(Depth)) u_back (
    .clk_i, .rst_ni,
    .push_i(push), .work_i(work), .full_o(full),
    .valid_o(out_ch.valid), .beat_o(out_ch.data), .ready_i(out_ch.ready)
  );

endmodule

// ===== rtl/sexpr_checker.sv =====
// Port-level checker for the s-expression token lexer, bound to the top level.
module sexpr_checker import sexpr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_beat_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output beat changed while stalled");

  a_text_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.result_kind |-> out_data_i.token_kind == TOK_END &&
      out_data_i.number_value == 64'sd0)
    else $error("text beat carries token fields");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.fraction_digits <= 5'(MaxFrac))
    else $error("fraction count out of range");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_kind && out_data_i.token_kind == TOK_END |->
      out_data_i.last_of_run)
    else $error("end token not last of run");

  a_in_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind sexpr_token_lexer sexpr_checker u_checker (
  .clk_i, .rst_ni,
  .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data)
);
